// ===== hw/rtl/wss_pkg.sv =====
// Shared types and constants for the wildcard signature scanner.
`timescale 1ns / 1ps

package wss_pkg;

    localparam int SIG_BYTES     = 24;
    localparam int LEN_W         = 5;
    localparam int SKIP_W        = 16;
    localparam int OFFSET_W      = 24;
    localparam int SEEN_W        = 25;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW     = 3'd0,
        REG_PATTERN_MID     = 3'd1,
        REG_PATTERN_HIGH    = 3'd2,
        REG_CARE_MASK       = 3'd3,
        REG_PATTERN_LENGTH  = 3'd4,
        REG_SKIP_COUNT      = 3'd5,
        REG_SEARCH_DISTANCE = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [SIG_BYTES*8-1:0] pattern;
        logic [SIG_BYTES-1:0]   care;
        logic [LEN_W-1:0]       length;
        logic [SKIP_W-1:0]      skip;
        logic [OFFSET_W-1:0]    distance;
    } cfg_t;

    localparam logic [SIG_BYTES-1:0] CARE_RESET     = '1;
    localparam logic [LEN_W-1:0]     LENGTH_RESET   = 5'd1;
    localparam logic [OFFSET_W-1:0]  DISTANCE_RESET = 24'd1;
    localparam logic [SEEN_W-1:0]    SEEN_MAX       = '1;

endpackage

// ===== hw/rtl/wss_cfg_regs.sv =====
// Configuration register file of the wildcard signature scanner.
`timescale 1ns / 1ps

module wss_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wss_pkg::cfg_t                      cfg
);

    wss_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern  <= '0;
            cfg_reg.care     <= wss_pkg::CARE_RESET;
            cfg_reg.length   <= wss_pkg::LENGTH_RESET;
            cfg_reg.skip     <= '0;
            cfg_reg.distance <= wss_pkg::DISTANCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wss_pkg::reg_index_t'(cfg_index))
                wss_pkg::REG_PATTERN_LOW:
                    cfg_reg.pattern[63:0] <= cfg_data;
                wss_pkg::REG_PATTERN_MID:
                    cfg_reg.pattern[127:64] <= cfg_data;
                wss_pkg::REG_PATTERN_HIGH:
                    cfg_reg.pattern[191:128] <= cfg_data;
                wss_pkg::REG_CARE_MASK:
                    cfg_reg.care <= cfg_data[wss_pkg::SIG_BYTES-1:0];
                wss_pkg::REG_PATTERN_LENGTH:
                    cfg_reg.length <= cfg_data[wss_pkg::LEN_W-1:0];
                wss_pkg::REG_SKIP_COUNT:
                    cfg_reg.skip <= cfg_data[wss_pkg::SKIP_W-1:0];
                wss_pkg::REG_SEARCH_DISTANCE:
                    cfg_reg.distance <= cfg_data[wss_pkg::OFFSET_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/wss_match.sv =====
// Parallel window compare against the wildcard signature.
`timescale 1ns / 1ps

module wss_match
#(
    parameter int PATTERN_BYTES = 24
)
(
    input  logic [PATTERN_BYTES*8-1:0]       window,
    input  logic [wss_pkg::LEN_W-1:0]        len,
    input  wss_pkg::cfg_t                    cfg,
    output logic                             hit
);

    always_comb
    begin
        logic [wss_pkg::LEN_W-1:0] idx;
        logic [7:0]                sig;
        logic                      care;
        hit = 1'b1;
        for (int j = 0; j < PATTERN_BYTES; j++)
        begin
            idx  = len - wss_pkg::LEN_W'(j) - wss_pkg::LEN_W'(1);
            sig  = '0;
            care = 1'b0;
            if (wss_pkg::LEN_W'(j) < len)
            begin
                sig  = cfg.pattern[idx*8 +: 8];
                care = cfg.care[idx];
            end
            if (care && (window[j*8 +: 8] != sig))
            begin
                hit = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/wildcard_signature_scanner_core.sv =====
// Top level of the wildcard signature scanner: item register, scan state, result register.
//
// Usage: configure the signature through the cfg channel (valid/ready, index and
// 64-bit data, always ready) while the scanner is idle. Stream the region's bytes
// in ascending address order on the item channel (item_valid/item_stall), one byte
// per transfer, with last_byte high on the final one. Each region gives exactly one
// result on the result channel (result_valid/result_stall): found with the start
// offset of the (skip_count+1)-th match, or not found with offset zero.
// Path: each taken byte is held in the item register, then its result is registered.
// Throughput: one byte per cycle while result_stall holds no pending result; the
// window compare is a single combinational pass between the item and result registers.
// Reset: clears the configuration to its reset values and the scan state; no
// result is pending afterwards.
// Stall: while result_stall holds a pending result, the item register fills and
// item_stall rises; the pending result stays unchanged until taken.
`timescale 1ns / 1ps

module wildcard_signature_scanner_core
#(
    parameter int PATTERN_BYTES = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              found,
    output logic [wss_pkg::OFFSET_W-1:0]      match_offset
);

    localparam logic [wss_pkg::LEN_W-1:0] MAX_LEN = wss_pkg::LEN_W'(PATTERN_BYTES);
    localparam int WIN_W = PATTERN_BYTES * 8;

    wss_pkg::cfg_t                     cfg;
    logic                              item_full_reg;
    logic [7:0]                        byte_reg;
    logic                              last_reg;
    logic [PATTERN_BYTES*8-1:0]        window_reg;
    logic [PATTERN_BYTES*8-1:0]        window_next;
    logic [wss_pkg::SEEN_W-1:0]        seen_reg;
    logic [wss_pkg::SEEN_W-1:0]        seen_next;
    logic [wss_pkg::SKIP_W-1:0]        skipped_reg;
    logic [wss_pkg::SKIP_W-1:0]        skipped_next;
    logic                              done_reg;
    logic                              done_next;
    logic                              res_valid_reg;
    logic                              res_valid_next;
    logic                              found_reg;
    logic                              found_next;
    logic [wss_pkg::OFFSET_W-1:0]      offset_reg;
    logic [wss_pkg::OFFSET_W-1:0]      offset_next;
    logic [wss_pkg::LEN_W-1:0]         eff_len;
    logic [wss_pkg::SEEN_W-1:0]        seen_inc;
    logic [wss_pkg::SEEN_W-1:0]        start;
    logic                              candidate;
    logic                              hit;
    logic                              advance;
    logic                              item_take;

    wss_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wss_match #(.PATTERN_BYTES(PATTERN_BYTES)) u_match
    (
        .window (window_next),
        .len    (eff_len),
        .cfg    (cfg),
        .hit    (hit)
    );

    assign advance    = item_full_reg && (!res_valid_reg || !result_stall);
    assign item_stall = item_full_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    assign result_valid = res_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

    always_comb
    begin
        if (cfg.length == '0)
        begin
            eff_len = wss_pkg::LEN_W'(1);
        end
        else if (cfg.length > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = cfg.length;
        end
    end

    always_comb
    begin
        window_next = WIN_W'({window_reg, byte_reg});
        seen_inc    = (seen_reg == wss_pkg::SEEN_MAX) ? seen_reg : seen_reg + 1'b1;
        start       = seen_inc - wss_pkg::SEEN_W'(eff_len);
        candidate   = (seen_inc >= wss_pkg::SEEN_W'(eff_len)) &&
                      (start < wss_pkg::SEEN_W'(cfg.distance));
    end

    always_comb
    begin
        seen_next      = seen_reg;
        skipped_next   = skipped_reg;
        done_next      = done_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;
        res_valid_next = res_valid_reg && result_stall;
        if (advance)
        begin
            res_valid_next = 1'b0;
            if (!done_reg)
            begin
                seen_next = seen_inc;
                if (candidate && hit)
                begin
                    if (skipped_reg >= cfg.skip)
                    begin
                        done_next      = 1'b1;
                        res_valid_next = 1'b1;
                        found_next     = 1'b1;
                        offset_next    = start[wss_pkg::OFFSET_W-1:0];
                    end
                    else
                    begin
                        skipped_next = skipped_reg + 1'b1;
                    end
                end
                if (last_reg && !done_next)
                begin
                    res_valid_next = 1'b1;
                    found_next     = 1'b0;
                    offset_next    = '0;
                end
            end
            if (last_reg)
            begin
                seen_next    = '0;
                skipped_next = '0;
                done_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
            seen_reg      <= '0;
            skipped_reg   <= '0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_full_reg <= 1'b0;
            end
            seen_reg      <= seen_next;
            skipped_reg   <= skipped_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (advance && !done_reg)
        begin
            window_reg <= window_next;
        end
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the wildcard signature scanner core.
`timescale 1ns / 1ps

module testbench;

    import wss_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
    localparam int DRAIN_CYCLES = 4;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } scan_report_t;

    class signature_tracker;
        logic [SIG_BYTES*8-1:0] pattern;
        logic [SIG_BYTES-1:0]   care;
        logic [LEN_W-1:0]       length;
        logic [SKIP_W-1:0]      skip;
        logic [OFFSET_W-1:0]    distance;

        logic [7:0]             window[SIG_BYTES];
        logic [SEEN_W-1:0]      seen;
        logic [SKIP_W-1:0]      skipped;
        bit                     done;

        scan_report_t           expected_reports[$];
        int                     mismatches;
        int                     checked;

        function new();
            pattern    = '0;
            care       = CARE_RESET;
            length     = LENGTH_RESET;
            skip       = '0;
            distance   = DISTANCE_RESET;
            mismatches = 0;
            checked    = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i])
                window[i] = 8'h00;
            seen    = '0;
            skipped = '0;
            done    = 1'b0;
        endfunction

        function int eff_length();
            int n;
            n = int'(length);
            if (n < 1)
                n = 1;
            if (n > SIG_BYTES)
                n = SIG_BYTES;
            return n;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PATTERN_LOW:     pattern[63:0]    = data;
                REG_PATTERN_MID:     pattern[127:64]  = data;
                REG_PATTERN_HIGH:    pattern[191:128] = data;
                REG_CARE_MASK:       care             = data[SIG_BYTES-1:0];
                REG_PATTERN_LENGTH:  length           = data[LEN_W-1:0];
                REG_SKIP_COUNT:      skip             = data[SKIP_W-1:0];
                REG_SEARCH_DISTANCE: distance         = data[OFFSET_W-1:0];
                default:             ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int len;
            int start;
            int k;
            bit hit;
            scan_report_t rep;
            if (!done)
            begin
                len = eff_length();
                for (k = SIG_BYTES - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = b;
                if (seen != SEEN_MAX)
                    seen = seen + 1'b1;
                if (int'(seen) >= len)
                begin
                    start = int'(seen) - len;
                    if (start < int'(distance))
                    begin
                        hit = 1'b1;
                        for (k = 0; k < len; k++)
                            if (care[k] && window[len-1-k] != pattern[k*8 +: 8])
                                hit = 1'b0;
                        if (hit)
                        begin
                            if (skipped >= skip)
                            begin
                                rep.found  = 1'b1;
                                rep.offset = start[OFFSET_W-1:0];
                                expected_reports.push_back(rep);
                                done = 1'b1;
                            end
                            else
                                skipped = skipped + 1'b1;
                        end
                    end
                end
                if (last && !done)
                begin
                    rep.found  = 1'b0;
                    rep.offset = '0;
                    expected_reports.push_back(rep);
                end
            end
            if (last)
                clear_scan();
        endfunction

        function void check_report(logic got_found, logic [OFFSET_W-1:0] got_offset);
            scan_report_t rep;
            checked++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: found=%0d offset=%0d",
                             $realtime, got_found, got_offset);
                return;
            end
            rep = expected_reports.pop_front();
            if (got_found !== rep.found || got_offset !== rep.offset)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                             $realtime, rep.found, rep.offset, got_found, got_offset);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   item_valid   = 1'b0;
    logic                   item_stall;
    logic [7:0]             data_byte    = 8'h00;
    logic                   last_byte    = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic                   found;
    logic [OFFSET_W-1:0]    match_offset;

    signature_tracker tracker;
    int send_idle = 28;
    int recv_idle = 53;
    int items_sent = 0;
    int regions_sent = 0;
    int settings_applied = 0;

    wildcard_signature_scanner_core #(
        .PATTERN_BYTES (SIG_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                tracker.check_report(found, match_offset);
            if (item_valid && !item_stall)
                tracker.note_byte(data_byte, last_byte);
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic cfg_t setting(logic [SIG_BYTES*8-1:0] pat, logic [SIG_BYTES-1:0] care,
                                     logic [LEN_W-1:0] len, logic [SKIP_W-1:0] skip,
                                     logic [OFFSET_W-1:0] dist_limit);
        cfg_t s;
        s.pattern  = pat;
        s.care     = care;
        s.length   = len;
        s.skip     = skip;
        s.distance = dist_limit;
        return s;
    endfunction

    function automatic cfg_t pick_setting();
        cfg_t s;
        s.pattern = {rand64(), rand64(), rand64()};
        if ($urandom_range(9) == 0)
            s.pattern = '0;
        else if ($urandom_range(9) == 0)
            s.pattern = '1;
        case ($urandom_range(9))
            0, 1, 2:    s.care = '1;
            3:          s.care = '0;
            4, 5:       s.care = SIG_BYTES'($urandom);
            default:    s.care = SIG_BYTES'($urandom | $urandom | $urandom);
        endcase
        case ($urandom_range(9))
            0:          s.length = 5'd1;
            1:          s.length = 5'd24;
            2:          s.length = 5'd0;
            3:          s.length = LEN_W'($urandom_range(25, 31));
            default:    s.length = LEN_W'($urandom_range(1, 8));
        endcase
        case ($urandom_range(7))
            0:          s.skip = '1;
            1:          s.skip = SKIP_W'($urandom);
            default:    s.skip = SKIP_W'($urandom_range(0, 3));
        endcase
        case ($urandom_range(9))
            0:          s.distance = '0;
            1:          s.distance = '1;
            2:          s.distance = OFFSET_W'($urandom);
            default:    s.distance = OFFSET_W'($urandom_range(1, 48));
        endcase
        return s;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_setting(cfg_t s);
        logic [63:0] junk;
        junk = rand64();
        write_reg(REG_PATTERN_LOW, s.pattern[63:0]);
        write_reg(REG_PATTERN_MID, s.pattern[127:64]);
        write_reg(REG_PATTERN_HIGH, s.pattern[191:128]);
        write_reg(REG_CARE_MASK, {junk[63:SIG_BYTES], s.care});
        write_reg(REG_PATTERN_LENGTH, {junk[63:LEN_W], s.length});
        write_reg(REG_SKIP_COUNT, {junk[63:SKIP_W], s.skip});
        write_reg(REG_SEARCH_DISTANCE, {junk[63:OFFSET_W], s.distance});
        write_reg(REG_SPARE, rand64());
        cfg_valid <= 1'b0;
        settings_applied++;
        @(posedge clk);
    endtask

    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (last)
            regions_sent++;
    endtask

    task automatic send_region(byte_q_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // hold off input until every pending result has been taken
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_region();
        byte_q_t bytes;
        int n;
        int len;
        int cut;
        int k;
        n = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        len = tracker.eff_length();
        while (bytes.size() < n)
        begin
            case ($urandom_range(5))
                0, 1:
                begin
                    for (k = 0; k < len; k++)
                        bytes.push_back(tracker.care[k] ? tracker.pattern[k*8 +: 8]
                                                        : 8'($urandom_range(255)));
                end
                2:
                begin
                    cut = $urandom_range(1, len);
                    for (k = 0; k < cut; k++)
                        bytes.push_back(tracker.care[k] ? tracker.pattern[k*8 +: 8]
                                                        : 8'($urandom_range(255)));
                end
                3:
                begin
                    k = $urandom_range(0, len - 1);
                    bytes.push_back(tracker.pattern[k*8 +: 8]);
                end
                default:
                    bytes.push_back(8'($urandom_range(255)));
            endcase
        end
        send_region(bytes);
    endtask

    initial
    begin
        int phase;
        int target[3];
        tracker = new();
        target[0] = 640;
        target[1] = 1250;
        target[2] = 1870;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single zero byte, then a byte after the report
        send_region('{8'h00, 8'hFF});
        wait_idle();

        // no candidate offsets
        apply_setting(setting('0, '1, 5'd1, '0, '0));
        send_region('{8'h00});
        wait_idle();

        // all wildcards, oversized length, region too short
        apply_setting(setting('1, '0, 5'd31, '0, '1));
        send_region('{8'hFF, 8'h00, 8'hFF});
        wait_idle();

        // zero length, every match skipped
        apply_setting(setting(192'hAB, '1, 5'd0, '1, '1));
        send_region('{8'hAB, 8'hAB});
        wait_idle();

        // skip lowered in the middle of a region
        apply_setting(setting(192'h3412, '1, 5'd2, 16'd2, '1));
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        wait_idle();
        apply_setting(setting(192'h3412, '1, 5'd2, 16'd0, '1));
        send_region('{8'h12, 8'h34, 8'h00});
        wait_idle();

        // match completed by the final byte, middle byte wildcard
        apply_setting(setting(192'hA55AC3, 24'h000005, 5'd3, '0, '1));
        send_region('{8'hC3, 8'h77, 8'hA5});
        wait_idle();

        // match only beyond the search distance
        apply_setting(setting(192'hFFFF, '1, 5'd2, '0, 24'd1));
        send_region('{8'hFF, 8'h00, 8'hFF, 8'hFF});
        wait_idle();

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 28 : (phase == 1) ? 53 : 0;
            recv_idle = (phase == 0) ? 53 : (phase == 1) ? 28 : 0;
            while (items_sent < target[phase])
            begin
                if ($urandom_range(1) == 0)
                begin
                    wait_idle();
                    apply_setting(pick_setting());
                end
                random_region();
            end
        end

        wait_idle();
        $display("Scanned %0d bytes in %0d regions under %0d register settings",
                 items_sent, regions_sent, settings_applied);
        $display("Checked %0d scan results, %0d mismatches", tracker.checked, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
